// ----- rtl/dlps_pkg.sv -----
// ----------------------------------------------------------------------------
// dlps_pkg - shared types and constants of the delay-line pitch shifter
// Sample and coefficient widths, register indexes, queue item, back-end states.
// ----------------------------------------------------------------------------
package dlps_pkg;

  localparam int SAMPLE_W = 24;   // audio sample, signed
  localparam int MIX_W    = 16;   // wet share, Q1.15
  localparam int STEP_W   = 17;   // read pointer increment, Q.16
  localparam int FRAC_W   = 16;   // fraction bits of the read pointer

  // dry/wet products: signed sample times unsigned 16-bit weight
  localparam int MULW  = SAMPLE_W + MIX_W + 1;
  // interpolation product: 25-bit difference times unsigned fraction
  localparam int IPW   = SAMPLE_W + 1 + FRAC_W + 1;

  localparam logic [MIX_W-1:0]  MIX_ONE    = 16'h8000;
  localparam logic [STEP_W-1:0] STEP_RESET = 17'h10000;
  localparam int                MIX_SHIFT  = 15;

  localparam logic signed [MULW:0] ROUND_HALF = (MULW+1)'(16384);
  localparam logic signed [MULW:0] SAT_HI     = (MULW+1)'(8388607);
  localparam logic signed [MULW:0] SAT_LO     = -(MULW+1)'(8388608);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = STEP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX    = 2'd0,
    CFG_STEP   = 2'd1,
    CFG_BYPASS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [MIX_W-1:0]  mix;
    logic [STEP_W-1:0] step;
    logic              bypass;
  } cfg_t;

  // one queued sample, classified by the front end
  typedef struct packed {
    logic                       pass;     // goes straight to the output
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  localparam int           QUEUE_DEPTH = 2;
  localparam logic [1:0]   QUEUE_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,     // take queue head; write store, read first tap
    S_SECOND,   // read second tap, latch first tap, dry product
    S_INTERP,   // (s2 - s1) * frac
    S_WET,      // wet value times mix
    S_SUM       // round, saturate, hand to output register
  } back_state_t;

endpackage

// ----- rtl/dlps_front.sv -----
// ----------------------------------------------------------------------------
// dlps_front - input acceptance, classification and two-entry queue
// Marks pass-through samples and buffers items for the back end.
// ----------------------------------------------------------------------------
module dlps_front import dlps_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [23:0] sample_in
  input  logic [0:0]          s_tuser,   // [0] channel
  input  logic                bypass,
  output item_t               q_item,
  output logic                q_valid,
  input  logic                q_pop
);

  localparam logic HAS_CH1 = (CHANNELS > 1);

  item_t      q [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      in_item;

  assign s_tready = (count != QUEUE_FULL);
  assign push     = s_tvalid && s_tready;

  always_comb begin
    in_item.channel = s_tuser[0];
    in_item.sample  = $signed(s_tdata);
    // channel without a store passes through like bypass
    in_item.pass    = bypass | (s_tuser[0] & ~HAS_CH1);
  end

  assign q_valid = (count != 2'd0);
  assign q_item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= QUEUE_FULL)
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !q_pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not grow on push");
  a_count_dn: assert property (@(posedge clk) disable iff (rst)
    q_pop && !push |=> count == $past(count) - 2'd1)
    else $error("queue count did not shrink on pop");
`endif

endmodule

// ----- rtl/dlps_back.sv -----
// ----------------------------------------------------------------------------
// dlps_back - delay store, pointers, interpolation and dry/wet mix
// Sequencer that runs one queued item at a time into the output register.
// ----------------------------------------------------------------------------
module dlps_back import dlps_pkg::*; #(
  parameter int DELAY_DEPTH = 4096,
  parameter int CHANNELS    = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  item_t               q_item,
  input  logic                q_valid,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // [23:0] sample_out
  output logic [0:0]          m_tuser    // [0] channel_out
);

  localparam int NCH   = (CHANNELS > 1) ? 2 : 1;
  localparam int IW    = $clog2(DELAY_DEPTH);
  localparam int PW    = IW + FRAC_W;
  localparam int AW    = IW + $clog2(NCH);
  localparam int WORDS = NCH << IW;
  localparam logic [PW:0]   DEPTH_EXT = (PW+1)'(DELAY_DEPTH);
  localparam logic [PW:0]   SPAN      = DEPTH_EXT << FRAC_W;
  localparam logic [IW-1:0] LAST_IDX  = IW'(DELAY_DEPTH - 1);

  // delay store
  logic signed [SAMPLE_W-1:0] mem [0:WORDS-1];
  logic signed [SAMPLE_W-1:0] rdata;
  logic                       mem_we;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;

  // per-channel pointers; filled marks a store that has wrapped once
  logic [IW-1:0] widx   [NCH];
  logic [PW-1:0] rptr   [NCH];
  logic          filled [NCH];

  back_state_t state, state_next;

  // item in flight
  logic                       ch_r;
  logic signed [SAMPLE_W-1:0] dry_r;
  logic [IW-1:0]              i2_r;
  logic [FRAC_W-1:0]          frac_r;
  logic                       fwd1_r;
  logic                       v1_r;
  logic                       v2_r;
  logic signed [SAMPLE_W-1:0] s1_r;
  logic signed [MULW-1:0]     dry_prod_r;
  logic signed [IPW-1:0]      ip_prod_r;
  logic signed [MULW-1:0]     wet_prod_r;

  // output register
  logic                       out_valid;
  logic                       out_ch;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_free;
  logic                       load_pass;
  logic                       load_sum;

  // queue head view
  logic          h_ch;
  logic [IW-1:0] h_w;
  logic [PW-1:0] h_rp;
  logic [IW-1:0] h_i1;
  logic [IW-1:0] h_i2;
  logic          h_filled;
  logic [PW:0]   rp_sum;
  logic [PW:0]   rp_wrap;

  // arithmetic
  logic [MIX_W-1:0]             a_eff;
  logic [MIX_W-1:0]             dry_wt;
  logic signed [SAMPLE_W-1:0]   s2;
  logic signed [SAMPLE_W:0]     diff;
  logic signed [IPW-1:0]        ip_shift;
  logic signed [SAMPLE_W+1:0]   wet_full;
  logic signed [SAMPLE_W-1:0]   wet;
  logic signed [MULW:0]         acc;
  logic signed [MULW:0]         acc_sh;
  logic signed [SAMPLE_W-1:0]   result;

  always_comb begin
    h_ch     = q_item.channel;
    h_w      = widx[h_ch];
    h_rp     = rptr[h_ch];
    h_filled = filled[h_ch];
    h_i1     = h_rp[PW-1:FRAC_W];
    h_i2     = (h_i1 == LAST_IDX) ? '0 : h_i1 + 1'b1;
    rp_sum   = {1'b0, h_rp} + (PW+1)'(cfg.step);
    rp_wrap  = (rp_sum >= SPAN) ? rp_sum - SPAN : rp_sum;
  end

  assign wr_addr = AW'({h_ch, h_w});
  assign rd_addr = (state == S_IDLE) ? AW'({h_ch, h_i1}) : AW'({ch_r, i2_r});

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_item.sample;
    end
    rdata <= mem[rd_addr];
  end

  assign out_free = !out_valid || m_tready;

  // sequencer
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    load_pass  = 1'b0;
    load_sum   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.pass) begin
            if (out_free) begin
              q_pop     = 1'b1;
              load_pass = 1'b1;
            end
          end else begin
            q_pop      = 1'b1;
            mem_we     = 1'b1;
            state_next = S_SECOND;
          end
        end
      end
      S_SECOND: state_next = S_INTERP;
      S_INTERP: state_next = S_WET;
      S_WET:    state_next = S_SUM;
      S_SUM: begin
        if (out_free) begin
          load_sum   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pointer update when an item starts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCH; c++) begin
        widx[c]   <= '0;
        rptr[c]   <= '0;
        filled[c] <= 1'b0;
      end
    end else if (mem_we) begin
      widx[h_ch]   <= (h_w == LAST_IDX) ? '0 : h_w + 1'b1;
      filled[h_ch] <= h_filled | (h_w == LAST_IDX);
      rptr[h_ch]   <= rp_wrap[PW-1:0];
    end
  end

  // arithmetic datapath
  always_comb begin
    a_eff    = (cfg.mix > MIX_ONE) ? MIX_ONE : cfg.mix;
    dry_wt   = MIX_ONE - a_eff;
    s2       = v2_r ? rdata : '0;
    diff     = (SAMPLE_W+1)'(s2) - (SAMPLE_W+1)'(s1_r);
    ip_shift = ip_prod_r >>> FRAC_W;
    wet_full = (SAMPLE_W+2)'(s1_r) + ip_shift[SAMPLE_W+1:0];
    wet      = wet_full[SAMPLE_W-1:0];
    acc      = (MULW+1)'(dry_prod_r) + (MULW+1)'(wet_prod_r) + ROUND_HALF;
    acc_sh   = acc >>> MIX_SHIFT;
    if (acc_sh > SAT_HI) begin
      result = SAT_HI[SAMPLE_W-1:0];
    end else if (acc_sh < SAT_LO) begin
      result = SAT_LO[SAMPLE_W-1:0];
    end else begin
      result = acc_sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ch_r   <= h_ch;
      dry_r  <= q_item.sample;
      i2_r   <= h_i2;
      frac_r <= h_rp[FRAC_W-1:0];
      // first tap equal to the slot written this cycle takes the new sample
      fwd1_r <= (h_i1 == h_w);
      // entries never written read as zero
      v1_r   <= h_filled || (h_i1 <= h_w);
      v2_r   <= h_filled || (h_i2 <= h_w);
    end
    if (state == S_SECOND) begin
      s1_r       <= fwd1_r ? dry_r : (v1_r ? rdata : '0);
      dry_prod_r <= MULW'(dry_r) * MULW'($signed({1'b0, dry_wt}));
    end
    if (state == S_INTERP) begin
      ip_prod_r <= IPW'(diff) * IPW'($signed({1'b0, frac_r}));
    end
    if (state == S_WET) begin
      wet_prod_r <= MULW'(wet) * MULW'($signed({1'b0, a_eff}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_pass || load_sum) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pass) begin
      out_ch     <= q_item.channel;
      out_sample <= q_item.sample;
    end else if (load_sum) begin
      out_ch     <= ch_r;
      out_sample <= result;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_sample;
  assign m_tuser[0] = out_ch;

`ifndef NO_ASSERTIONS
  a_rptr_range: assert property (@(posedge clk) disable iff (rst) {1'b0, rptr[0]} < SPAN)
    else $error("read pointer beyond store span");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    state == S_SECOND |=> state == S_INTERP)
    else $error("sequencer skipped interpolation");
  a_widx_step: assert property (@(posedge clk) disable iff (rst)
    mem_we && !h_ch |=> widx[0] != $past(widx[0]))
    else $error("write index did not advance");
`endif

endmodule

// ----- rtl/delay_line_pitch_shifter.sv -----
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter - two-channel delay-line pitch shifter
// Circular delay store per channel, fractional read pointer with linear
// interpolation, dry/wet mix with rounding and 24-bit saturation.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata[23:0] sample_in, tuser[0] channel
//  m_*      out  m_tvalid/m_tready  tdata[23:0] sample_out, tuser[0] channel_out
//  cfg_*    in   cfg_we             cfg_index (0 mix, 1 step, 2 bypass), cfg_data
//
//  A delayed sample runs through the back-end sequencer states in order: the store
//  write with the first tap read, the second tap read on the single read port,
//  then one multiply per cycle (interpolation, wet share) and the rounding sum.
//  Pass-through samples (bypass, storeless channel) go straight to the output.
//  Reset clears pointers and per-channel fill flags; the store itself is not
//  swept, entries not yet written read as zero.
//  A two-entry queue lets the input accept two samples while the output stalls.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter import dlps_pkg::*; #(
  parameter int DELAY_DEPTH = 4096,
  parameter int CHANNELS    = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [SAMPLE_W-1:0]  s_tdata,    // [23:0] sample_in
  input  logic [0:0]           s_tuser,    // [0] channel
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [SAMPLE_W-1:0]  m_tdata,    // [23:0] sample_out
  output logic [0:0]           m_tuser,    // [0] channel_out
  // register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // configuration regs: write only while no transaction is in flight, unchecked
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mix    <= '0;
      cfg.step   <= STEP_RESET;
      cfg.bypass <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MIX:    cfg.mix    <= cfg_data[MIX_W-1:0];
        CFG_STEP:   cfg.step   <= cfg_data[STEP_W-1:0];
        CFG_BYPASS: cfg.bypass <= cfg_data[0];
        default:    ;  // unmapped index, ignored
      endcase
    end
  end

  // front end: accept and classify each input transaction
  dlps_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .bypass   (cfg.bypass),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  // back end: store access, interpolation, mix, output register
  dlps_back #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .CHANNELS    (CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
